>>> hw/rtl/circle_inlier_scoring_assert.svh
// ----------------------------------------------------------------------------
// circle_inlier_scoring assertion macros
// shared concurrent assertion forms, clocked on i_clk
// ----------------------------------------------------------------------------
`ifndef CIRCLE_INLIER_SCORING_ASSERT_SVH
`define CIRCLE_INLIER_SCORING_ASSERT_SVH

// property checked only outside reset
`define CIS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define CIS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> hw/rtl/cis_pkg.sv
// ----------------------------------------------------------------------------
// cis_pkg
// types and constants shared by the circle inlier scoring block
// ----------------------------------------------------------------------------
package cis_pkg;

    // field widths of the beats
    localparam int COORD_W     = 32;
    localparam int INDEX_W     = 20;
    localparam int RADIUS_W    = 31;
    localparam int DIST_W      = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 4;

    // defaults of the top level parameters
    localparam int COORD_BITS_DEF = 32;
    localparam int INDEX_BITS_DEF = 20;

    // job queue depth, power of two
    localparam int QUEUE_DEPTH = 2;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_X  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_Y  = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_RADIUS    = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = CFG_INDEX_W'(3);

    // input beat
    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [INDEX_W-1:0]        point_index;
        logic                      last_point;
    } t_cis_in;

    // output beat
    typedef struct packed {
        logic [INDEX_W-1:0] out_index;
        logic [DIST_W-1:0]  circle_distance;
        logic               is_inlier;
        logic               within_limit;
        logic               all_within;
        logic               out_last;
    } t_cis_out;

    // classified job between front and back
    typedef struct packed {
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [INDEX_W-1:0] index;
        logic               last;
    } t_cis_job;

endpackage

>>> hw/rtl/cis_front.sv
// ----------------------------------------------------------------------------
// cis_front
// takes input beats and turns each point into absolute offsets from the centre
// ----------------------------------------------------------------------------
module cis_front
    import cis_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [COORD_BITS-1:0] i_center_x,
    input  logic [COORD_BITS-1:0] i_center_y,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_cis_in               i_in,
    output logic                  o_job_valid,
    input  logic                  i_job_ready,
    output t_cis_job              o_job
);

    localparam int IDX_KEEP = (INDEX_BITS < INDEX_W) ? INDEX_BITS : INDEX_W;

    logic            r_valid;
    t_cis_job        r_job;
    logic [COORD_BITS:0]   w_dx, w_dy, w_ndx, w_ndy;
    logic [COORD_BITS-1:0] w_ax, w_ay;
    logic            w_take;

    // signed differences, one bit wider than the coordinates
    assign w_dx  = {i_in.point_x[COORD_BITS-1], i_in.point_x[COORD_BITS-1:0]}
                 - {i_center_x[COORD_BITS-1], i_center_x};
    assign w_dy  = {i_in.point_y[COORD_BITS-1], i_in.point_y[COORD_BITS-1:0]}
                 - {i_center_y[COORD_BITS-1], i_center_y};
    assign w_ndx = (~w_dx) + 1'b1;
    assign w_ndy = (~w_dy) + 1'b1;

    // magnitudes always fit the coordinate width
    assign w_ax = w_dx[COORD_BITS] ? w_ndx[COORD_BITS-1:0] : w_dx[COORD_BITS-1:0];
    assign w_ay = w_dy[COORD_BITS] ? w_ndy[COORD_BITS-1:0] : w_dy[COORD_BITS-1:0];

    assign o_in_ready = !r_valid || i_job_ready;
    assign w_take     = i_in_valid && o_in_ready;

    // stage register toward the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_job_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_job.ax    <= COORD_W'(w_ax);
            r_job.ay    <= COORD_W'(w_ay);
            r_job.index <= INDEX_W'(i_in.point_index[IDX_KEEP-1:0]);
            r_job.last  <= i_in.last_point;
        end
    end

    assign o_job_valid = r_valid;
    assign o_job       = r_job;

endmodule

>>> hw/rtl/cis_queue.sv
// ----------------------------------------------------------------------------
// cis_queue
// small register queue of jobs between front and back
// ----------------------------------------------------------------------------
module cis_queue
    import cis_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_wr_valid,
    output logic     o_wr_ready,
    input  t_cis_job i_wr_job,
    output logic     o_rd_valid,
    input  logic     i_rd_ready,
    output t_cis_job o_rd_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cis_job           r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               w_push, w_pop;

    assign o_wr_ready = (r_count != CNT_W'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;
    assign o_rd_job   = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr_job;
        end
    end

endmodule

>>> hw/rtl/cis_back.sv
// ----------------------------------------------------------------------------
// cis_back
// squares, bit-serial square root, distance to circle and output register
// ----------------------------------------------------------------------------
module cis_back
    import cis_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [RADIUS_W-1:0] i_radius,
    input  logic [RADIUS_W-1:0] i_threshold,
    input  logic                i_job_valid,
    output logic                o_job_ready,
    input  t_cis_job            i_job,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_cis_out            o_out
);

    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int ROOT_W = COORD_BITS + 1;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 3;
    localparam int STEP_W = $clog2(ROOT_W);
    localparam int DIFF_W = (ROOT_W > RADIUS_W) ? ROOT_W : RADIUS_W;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ROOT_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_SUM,
        S_ROOT,
        S_DIST,
        S_FINISH
    } t_state;

    t_state              r_state;
    logic [COORD_BITS-1:0] r_ax, r_ay;
    logic [INDEX_W-1:0]  r_index;
    logic                r_last;
    logic [SQ_W-1:0]     r_sq_x, r_sq_y;
    logic [RAD_W-1:0]    r_rad;
    logic [REM_W-1:0]    r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [STEP_W-1:0]   r_step;
    logic [DIST_W-1:0]   r_dist;
    logic                r_out_valid;
    t_cis_out            r_out;
    logic                r_set_all_within;

    logic [REM_W-1:0]    w_rem_sh, w_trial;
    logic                w_fit;
    logic [DIFF_W-1:0]   w_root_ext, w_rad_ext, w_diff;
    logic                w_sat;
    logic                w_inlier, w_within, w_all;

    // one root bit per step, restoring form
    assign w_rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign w_trial  = REM_W'({r_root, 2'b01});
    assign w_fit    = (w_rem_sh >= w_trial);

    // absolute difference to the radius with saturation
    assign w_root_ext = DIFF_W'(r_root);
    assign w_rad_ext  = DIFF_W'(i_radius);
    assign w_diff     = (w_root_ext >= w_rad_ext) ? (w_root_ext - w_rad_ext)
                                                  : (w_rad_ext - w_root_ext);
    assign w_sat      = ((w_diff >> DIST_W) != '0);

    // threshold compares on the stored distance
    assign w_inlier = (r_dist <  DIST_W'(i_threshold));
    assign w_within = (r_dist <= DIST_W'(i_threshold));
    assign w_all    = r_set_all_within && w_within;

    assign o_job_ready = (r_state == S_IDLE);

    // sequencer, datapath registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_out_valid      <= 1'b0;
            r_set_all_within <= 1'b1;
        end else begin
            // result beat handshake
            if (r_state == S_FINISH && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_ax    <= i_job.ax[COORD_BITS-1:0];
                        r_ay    <= i_job.ay[COORD_BITS-1:0];
                        r_index <= i_job.index;
                        r_last  <= i_job.last;
                        r_state <= S_SQUARE;
                    end
                end
                S_SQUARE: begin
                    r_sq_x  <= r_ax * r_ax;
                    r_sq_y  <= r_ay * r_ay;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_rad   <= RAD_W'(r_sq_x) + RAD_W'(r_sq_y);
                    r_rem   <= '0;
                    r_root  <= '0;
                    r_step  <= '0;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    r_rad  <= r_rad << 2;
                    r_rem  <= w_fit ? (w_rem_sh - w_trial) : w_rem_sh;
                    r_root <= {r_root[ROOT_W-2:0], w_fit};
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_LAST) begin
                        r_state <= S_DIST;
                    end
                end
                S_DIST: begin
                    r_dist  <= w_sat ? '1 : DIST_W'(w_diff);
                    r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out.out_index       <= r_index;
                        r_out.circle_distance <= r_dist;
                        r_out.is_inlier       <= w_inlier;
                        r_out.within_limit    <= w_within;
                        r_out.all_within      <= w_all;
                        r_out.out_last        <= r_last;
                        r_set_all_within      <= r_last ? 1'b1 : w_all;
                        r_state               <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

>>> hw/rtl/circle_inlier_scoring.sv
// ----------------------------------------------------------------------------
// circle_inlier_scoring
// scores 2d points against a configured circle, one result beat per point
// ----------------------------------------------------------------------------
// usage:
//   input channel i_in_valid / o_in_ready carries one point beat: x, y,
//   index and a last mark. output channel o_out_valid / i_out_ready returns
//   one beat per point in order: index, distance to the circle, inlier and
//   within-limit flags, the running all-within flag and the last mark.
//   centre, radius and threshold are written through i_cfg_we / i_cfg_index /
//   i_cfg_data while no point is in flight.
//   the back end scores one point at a time and takes the next job only once
//   the last result is registered; its pace is set by the square-root unit,
//   which resolves one root bit per cycle over COORD_BITS + 1 steps.
//   the front stage and a two-entry job queue keep taking points while the
//   back end works or a result waits; when the receiver stalls the result
//   beat holds and input backs up once the queue is full.
//   reset clears the circle registers to zero, empties the front stage and
//   the queue, drops the result beat and re-arms the all-within flag.
// ----------------------------------------------------------------------------
`include "circle_inlier_scoring_assert.svh"

module circle_inlier_scoring
    import cis_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int INDEX_BITS = INDEX_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  t_cis_in                i_in,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_cis_out               o_out
);

    logic [COORD_BITS-1:0] r_center_x, r_center_y;
    logic [RADIUS_W-1:0]   r_radius, r_threshold;

    logic     w_front_valid, w_front_ready;
    t_cis_job w_front_job;
    logic     w_queue_valid, w_queue_ready;
    t_cis_job w_queue_job;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x  <= '0;
            r_center_y  <= '0;
            r_radius    <= '0;
            r_threshold <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CENTER_X:  r_center_x  <= i_cfg_data[COORD_BITS-1:0];
                CFG_CENTER_Y:  r_center_y  <= i_cfg_data[COORD_BITS-1:0];
                CFG_RADIUS:    r_radius    <= i_cfg_data[RADIUS_W-1:0];
                CFG_THRESHOLD: r_threshold <= i_cfg_data[RADIUS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // front: offsets from the centre
    cis_front #(
        .COORD_BITS (COORD_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_center_x  (r_center_x),
        .i_center_y  (r_center_y),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_job_valid (w_front_valid),
        .i_job_ready (w_front_ready),
        .o_job       (w_front_job)
    );

    // job queue
    cis_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_front_valid),
        .o_wr_ready (w_front_ready),
        .i_wr_job   (w_front_job),
        .o_rd_valid (w_queue_valid),
        .i_rd_ready (w_queue_ready),
        .o_rd_job   (w_queue_job)
    );

    // back: root, distance and result beat
    cis_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_radius    (r_radius),
        .i_threshold (r_threshold),
        .i_job_valid (w_queue_valid),
        .o_job_ready (w_queue_ready),
        .i_job       (w_queue_job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // result flag consistency, and no valid result beat out of reset
    `CIS_ASSERT(a_inlier_within, o_out_valid && o_out.is_inlier |-> o_out.within_limit, "inlier beat not within limit")
    `CIS_ASSERT(a_all_within, o_out_valid && o_out.all_within |-> o_out.within_limit, "all-within set on a point outside the limit")
    `CIS_ASSERT(a_sat_outside, o_out_valid && (o_out.circle_distance == '1) |-> !o_out.within_limit, "saturated distance reported within limit")
    `CIS_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid, "result beat valid right after reset")

endmodule
